// File: rtl/core/ultrasonic_echo_ranger_core_macros.svh
// Assertion macros used by the echo ranger top level.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UER_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UER_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/uer_pkg.sv
// Package for the echo ranger: phase and register codes, configuration struct.
// No dependencies.
package uer_pkg;

  localparam int SENSOR_COUNT      = 4;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int PIN_W             = 4;
  localparam int SEL_W             = 2;
  localparam int RES_W             = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 2;

  localparam logic [9:0]  CPU_RESET     = 10'd100;
  localparam logic [7:0]  CLEAR_RESET   = 8'd2;
  localparam logic [7:0]  TRIGGER_RESET = 8'd10;
  // 343000 mm/s halved, per microsecond, in Q16, truncated
  localparam logic [15:0] SCALE_RESET   = 16'((64'd343000 * 64'd65536) / (64'd2 * 64'd1000000));

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CLEAR   = 3'd1,
    PH_TRIGGER = 3'd2,
    PH_WAIT    = 3'd3,
    PH_MEASURE = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_US = 2'd0,
    CFG_CLEAR_TIME    = 2'd1,
    CFG_TRIGGER_TIME  = 2'd2,
    CFG_SCALE         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  counts_per_us;
    logic [7:0]  clear_time_us;
    logic [7:0]  trigger_time_us;
    logic [15:0] mm_per_us_q16;
  } cfg_t;

endpackage

// File: rtl/core/uer_if.sv
// Valid/ready channel interfaces for the echo ranger input and result streams.
// Depends on uer_pkg for field widths.
interface uer_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [uer_pkg::SEL_W-1:0]  sensor_select;
  logic [uer_pkg::PIN_W-1:0]  echo_pins;

  modport source (output valid, command, sensor_select, echo_pins, input ready);
  modport sink   (input valid, command, sensor_select, echo_pins, output ready);
endinterface

interface uer_out_if;
  logic                       valid;
  logic                       ready;
  logic [uer_pkg::PIN_W-1:0]  trigger_pins;
  logic                       busy_res;
  logic                       done_res;
  logic [uer_pkg::RES_W-1:0]  pulse_us;
  logic [uer_pkg::RES_W-1:0]  distance_mm;
  logic                       overflow;

  modport source (output valid, trigger_pins, busy_res, done_res, pulse_us, distance_mm,
                  overflow, input ready);
  modport sink   (input valid, trigger_pins, busy_res, done_res, pulse_us, distance_mm,
                  overflow, output ready);
endinterface

// File: rtl/core/uer_cfg_regs.sv
// Configuration register file of the echo ranger, written through a plain write port.
// Depends on uer_pkg.
module uer_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  wdata_i,
  output uer_pkg::cfg_t                   cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_COUNTS_PER_US: cfg_d.counts_per_us   = wdata_i[9:0];
        CFG_CLEAR_TIME:    cfg_d.clear_time_us   = wdata_i[7:0];
        CFG_TRIGGER_TIME:  cfg_d.trigger_time_us = wdata_i[7:0];
        CFG_SCALE:         cfg_d.mm_per_us_q16   = wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_us   <= CPU_RESET;
      cfg_q.clear_time_us   <= CLEAR_RESET;
      cfg_q.trigger_time_us <= TRIGGER_RESET;
      cfg_q.mm_per_us_q16   <= SCALE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/uer_tick_counter.sv
// Prescaler step: one clock tick through the microsecond prescaler and
// saturating microsecond counter. Combinational. Depends on uer_pkg.
module uer_tick_counter #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic [9:0]             counts_per_us_i,
  input  logic [9:0]             pre_i,
  input  logic [COUNT_WIDTH-1:0] micro_i,
  output logic [9:0]             pre_o,
  output logic [COUNT_WIDTH-1:0] micro_o,
  output logic                   sat_o
);
  import uer_pkg::*;

  logic [10:0] pre_inc;
  logic        wrap;

  assign pre_inc = {1'b0, pre_i} + 11'd1;
  // zero reload behaves as one tick per microsecond
  assign wrap    = pre_inc >= {1'b0, counts_per_us_i};

  always_comb begin
    pre_o   = pre_inc[9:0];
    micro_o = micro_i;
    sat_o   = 1'b0;
    if (wrap) begin
      pre_o = '0;
      if (&micro_i) begin
        sat_o = 1'b1;
      end else begin
        micro_o = micro_i + COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// File: rtl/core/uer_range_calc.sv
// Result scaling: saturated pulse width and distance in mm, from the microsecond count and Q16 scale.
// Combinational, one multiplier. Depends on uer_pkg.
module uer_range_calc #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]     count_i,
  input  logic [15:0]                scale_i,
  output logic [uer_pkg::RES_W-1:0]  pulse_o,
  output logic [uer_pkg::RES_W-1:0]  distance_o,
  output logic                       sat_o
);
  import uer_pkg::*;

  localparam int EXT_W  = (COUNT_WIDTH > RES_W) ? COUNT_WIDTH : RES_W;
  localparam int PROD_W = EXT_W + 16;

  logic [EXT_W-1:0]  count_ext;
  logic [PROD_W-1:0] product;
  logic [EXT_W-1:0]  dist_full;

  assign count_ext  = EXT_W'(count_i);
  assign product    = PROD_W'(count_ext) * PROD_W'(scale_i);
  assign dist_full  = EXT_W'(product >> 16);
  assign sat_o      = (count_ext >> RES_W) != '0;
  assign pulse_o    = sat_o ? '1 : count_ext[RES_W-1:0];
  assign distance_o = ((dist_full >> RES_W) != '0) ? '1 : dist_full[RES_W-1:0];

endmodule

// File: rtl/core/ultrasonic_echo_ranger_core.sv
// Echo ranger top level: input register, phase sequencer with counters, result register.
// Depends on uer_pkg, uer_if, uer_cfg_regs, uer_tick_counter, uer_range_calc and the macros header.
//
// Usage:
//  - in_i carries one transaction per clock tick of the sensor timebase: a start
//    command, the sensor to measure and the four echo levels.
//  - out_o returns exactly one transaction per input transaction, showing the
//    trigger levels, busy/done, the last pulse width and distance and the overflow flag.
//  - Configuration (prescaler reload, clear and trigger times, Q16 scale) is written
//    through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle.
// Timing:
//  - An accepted transaction lands in the input register; its result is loaded into the result
//    register when the sequencer advances, which a stall on out_o can hold off.
//  - One transaction per cycle sustained while out_o.ready stays high; the single sequencer
//    update and the COUNT_WIDTH x 16 distance multiplier (16x16 by default) sit between the registers.
// Reset: the sequencer goes idle, counters and the stored pulse, distance and overflow
//  clear, configuration takes its default values, no result is pending.
// Stall: while out_o.ready is low the result holds; the input register still takes
//  one more transaction, then in_i.ready drops until the result is taken.
module ultrasonic_echo_ranger_core #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  uer_in_if.sink                          in_i,
  uer_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import uer_pkg::*;

`include "ultrasonic_echo_ranger_core_macros.svh"

  cfg_t cfg;

  // Input register
  logic              in_valid_q;
  logic              cmd_q;
  logic [SEL_W-1:0]  sel_q;
  logic [PIN_W-1:0]  echo_q;
  logic              advance;
  logic              in_ready;

  // Sequencer state
  phase_e                   phase_q, phase_d;
  logic [9:0]               pre_q, pre_d;
  logic [COUNT_WIDTH-1:0]   micro_q, micro_d;
  logic [SEL_W-1:0]         active_q, active_d;
  logic                     sat_q, sat_d;
  logic [RES_W-1:0]         pulse_q, pulse_d;
  logic [RES_W-1:0]         dist_q, dist_d;
  logic                     done_d;

  // Result register
  logic              out_valid_q;
  logic [PIN_W-1:0]  trig_q;
  logic              busy_q;
  logic              done_q;

  // Counter step and scaling
  logic [9:0]             base_pre;
  logic [COUNT_WIDTH-1:0] base_micro;
  logic [9:0]             tick_pre;
  logic [COUNT_WIDTH-1:0] tick_micro;
  logic                   tick_sat;
  logic [RES_W-1:0]       calc_pulse;
  logic [RES_W-1:0]       calc_dist;
  logic                   calc_sat;

  logic echo;
  logic start_ok;
  logic clear_hit;
  logic trigger_hit;

  uer_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // The first tick of a pulse counts from zero
  assign base_pre   = (phase_q == PH_WAIT) ? '0 : pre_q;
  assign base_micro = (phase_q == PH_WAIT) ? '0 : micro_q;

  uer_tick_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_tick (
    .counts_per_us_i (cfg.counts_per_us),
    .pre_i           (base_pre),
    .micro_i         (base_micro),
    .pre_o           (tick_pre),
    .micro_o         (tick_micro),
    .sat_o           (tick_sat)
  );

  uer_range_calc #(.COUNT_WIDTH(COUNT_WIDTH)) u_calc (
    .count_i    (micro_q),
    .scale_i    (cfg.mm_per_us_q16),
    .pulse_o    (calc_pulse),
    .distance_o (calc_dist),
    .sat_o      (calc_sat)
  );

  // Handshake: the sequencer advances on a held input when the result register is free or drains now
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  assign echo        = echo_q[active_q];
  assign start_ok    = cmd_q && (32'(sel_q) < SENSOR_COUNT);
  assign clear_hit   = tick_micro >= COUNT_WIDTH'(cfg.clear_time_us);
  assign trigger_hit = tick_micro >= COUNT_WIDTH'(cfg.trigger_time_us);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:    if (start_ok)    phase_d = PH_CLEAR;
      PH_CLEAR:   if (clear_hit)   phase_d = PH_TRIGGER;
      PH_TRIGGER: if (trigger_hit) phase_d = PH_WAIT;
      PH_WAIT:    if (echo)        phase_d = PH_MEASURE;
      PH_MEASURE: if (!echo)       phase_d = PH_IDLE;
      default:                     phase_d = PH_IDLE;
    endcase
  end

  // Counters, latched sensor and stored results
  always_comb begin
    pre_d    = pre_q;
    micro_d  = micro_q;
    active_d = active_q;
    sat_d    = sat_q;
    pulse_d  = pulse_q;
    dist_d   = dist_q;
    done_d   = 1'b0;
    unique case (phase_q) inside
      PH_IDLE: begin
        if (start_ok) begin
          active_d = sel_q;
          sat_d    = 1'b0;
          pre_d    = '0;
          micro_d  = '0;
        end
      end
      PH_CLEAR, PH_TRIGGER: begin
        pre_d   = tick_pre;
        micro_d = tick_micro;
        sat_d   = sat_q | tick_sat;
        if ((phase_q == PH_CLEAR) ? clear_hit : trigger_hit) begin
          pre_d   = '0;
          micro_d = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          pre_d   = tick_pre;
          micro_d = tick_micro;
          sat_d   = sat_q | tick_sat;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          pre_d   = tick_pre;
          micro_d = tick_micro;
          sat_d   = sat_q | tick_sat;
        end else begin
          pulse_d = calc_pulse;
          dist_d  = calc_dist;
          sat_d   = sat_q | calc_sat;
          pre_d   = '0;
          micro_d = '0;
          done_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Input register: hold while the sequencer cannot advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      cmd_q  <= in_i.command;
      sel_q  <= in_i.sensor_select;
      echo_q <= in_i.echo_pins;
    end
  end

  // Sequencer state: advance once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pre_q    <= '0;
      micro_q  <= '0;
      active_q <= '0;
      sat_q    <= 1'b0;
      pulse_q  <= '0;
      dist_q   <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      pre_q    <= pre_d;
      micro_q  <= micro_d;
      active_q <= active_d;
      sat_q    <= sat_d;
      pulse_q  <= pulse_d;
      dist_q   <= dist_d;
    end
  end

  // Result register: drop valid once taken, reload on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      trig_q <= (phase_d == PH_TRIGGER) ? (PIN_W'(1) << active_d) : '0;
      busy_q <= phase_d != PH_IDLE;
      done_q <= done_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.trigger_pins = trig_q;
  assign out_o.busy_res     = busy_q;
  assign out_o.done_res     = done_q;
  assign out_o.pulse_us     = pulse_q;
  assign out_o.distance_mm  = dist_q;
  assign out_o.overflow     = sat_q;

  `UER_ASSERT_IMP(a_done_idle, out_valid_q && done_q, !busy_q, "done result while busy")
  `UER_ASSERT_IMP(a_trig_onehot, out_valid_q && (trig_q != '0), $onehot(trig_q) && busy_q,
                  "trigger drive not one-hot or not busy")
  `UER_ASSERT_IMP(a_done_from_measure, advance && done_d, phase_q == PH_MEASURE,
                  "measurement done outside measure phase")
  `UER_ASSERT_NXT(a_counts_zero_idle, advance && (phase_d == PH_IDLE),
                  (micro_q == '0) && (pre_q == '0), "counters not cleared in idle")

endmodule
